/* rtl/joystick_to_arrow_and_mouse_unit_defines.svh */
// assertion macros for the checker file
`ifndef JOYSTICK_TO_ARROW_AND_MOUSE_UNIT_DEFINES_SVH
`define JOYSTICK_TO_ARROW_AND_MOUSE_UNIT_DEFINES_SVH

// same-cycle implication
`define JTAM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JTAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/jtam_pkg.sv */
`default_nettype none

package jtam_pkg;

   // sample width default
   localparam int ADC_BITS_DEFAULT = 12;

   // fixed arithmetic constants
   localparam int CENTRE        = 2048;
   localparam int MOUSE_DIV     = 25;
   localparam int SCROLL_DIV    = 500;
   localparam int LO_RANGE      = 1200;
   localparam int HI_RANGE      = 1800;
   localparam int MOUSE_WAIT    = 50;
   localparam int SCROLL_WAIT   = 100;
   localparam int ARROW_WAIT    = 10;

   // register widths and reset values
   localparam int MID_W         = 12;
   localparam int THR_W         = 11;
   localparam int PRESS_RESET   = 100;
   localparam int RELEASE_RESET = 80;

   // csr port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_MID_LEFT_X      = 3'd0,
      REG_MID_LEFT_Y      = 3'd1,
      REG_MID_RIGHT_H     = 3'd2,
      REG_MID_RIGHT_V     = 3'd3,
      REG_PRESS_THRESHOLD = 3'd4,
      REG_RELEASE_THRESH  = 3'd5
   } csr_index_type;

   // arrow bit positions
   localparam int BIT_RIGHT = 0;
   localparam int BIT_LEFT  = 1;
   localparam int BIT_DOWN  = 2;
   localparam int BIT_UP    = 3;

   // response layout
   localparam int KEY_W         = 4;
   localparam int MOVE_W        = 11;
   localparam int WHEEL_W       = 5;
   localparam int RSP_PRESS_LSB = 0;
   localparam int RSP_REL_LSB   = RSP_PRESS_LSB + KEY_W;
   localparam int RSP_MX_LSB    = RSP_REL_LSB + KEY_W;
   localparam int RSP_MY_LSB    = RSP_MX_LSB + MOVE_W;
   localparam int RSP_WH_LSB    = RSP_MY_LSB + MOVE_W;
   localparam int RSP_USED      = RSP_WH_LSB + WHEEL_W;
   localparam int RSP_W         = ((RSP_USED + 7) / 8) * 8;

   // request tdata width rounded to bytes
   function automatic int req_tdata_bits(input int adc_bits);
      return ((32 + 4 * adc_bits + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

/* rtl/joystick_to_arrow_and_mouse_unit.sv */
`default_nettype none

// Joystick frame to arrow keys, scroll wheel and mouse move. Every request frame
// (time stamp in ms, four ADC samples, scroll mode flag) produces exactly one
// response: arrow press/release masks from the left stick through hysteresis,
// a wheel step in scroll mode and a range-scaled mouse move from the right
// stick, each action rate limited on wrapping millisecond differences. A frame
// is taken every clock cycle unless the response side stalls; it is held in
// the input register, and the key, scroll and mouse logic between that register
// and the response register updates the held keys and time stamps in the same
// cycle as the response, so the next frame always sees the updated state.
// Constant divisions use reciprocal multipliers. Midpoints and thresholds are to
// be written through the csr port while no frame is in flight; the block does
// not enforce this. There is no clearing pass after reset.
module joystick_to_arrow_and_mouse_unit
   import jtam_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: now_ms, left_x_raw, left_y_raw, right_h_raw, right_v_raw (low bit up)
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [req_tdata_bits(ADC_BITS)-1:0]  req_tdata,
   input  logic                                 req_tuser,   // scroll_mode
   // response: arrow_press, arrow_release, move_x, move_y, wheel (low bit up)
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_W-1:0]                     rsp_tdata,
   output logic                                 rsp_tuser,   // mouse_valid
   // csr port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [CSR_AW-1:0]                    csr_paddr,
   input  logic [CSR_DW-1:0]                    csr_pwdata,
   output logic [CSR_DW-1:0]                    csr_prdata,
   output logic                                 csr_pready
);

   // datapath widths
   localparam int IN_USED = 32 + 4 * ADC_BITS;
   localparam int CW      = ((ADC_BITS > MID_W) ? ADC_BITS : MID_W) + 2;
   localparam int MW      = CW - 1;
   localparam int SMW     = MW + 2;

   // reciprocal of the scroll divisor, exact below 2**MW
   localparam int S_SCR   = MW + $clog2(SCROLL_DIV);
   localparam int KW_SCR  = MW + 2;
   localparam int PW_SCR  = MW + KW_SCR;
   localparam longint unsigned K_SCR_FULL =
      ((64'd1 << S_SCR) + SCROLL_DIV - 1) / SCROLL_DIV;
   localparam logic [KW_SCR-1:0] K_SCR = KW_SCR'(K_SCR_FULL);

   // reciprocal of the mouse divisor, exact below 2**SMW
   localparam int S_MOU   = SMW + $clog2(MOUSE_DIV);
   localparam int KW_MOU  = SMW + 2;
   localparam int PW_MOU  = SMW + KW_MOU;
   localparam longint unsigned K_MOU_FULL =
      ((64'd1 << S_MOU) + MOUSE_DIV - 1) / MOUSE_DIV;
   localparam logic [KW_MOU-1:0] K_MOU = KW_MOU'(K_MOU_FULL);

   // csr registers
   logic signed [MID_W-1:0] mid_lx_ff, mid_lx_in;
   logic signed [MID_W-1:0] mid_ly_ff, mid_ly_in;
   logic signed [MID_W-1:0] mid_rh_ff, mid_rh_in;
   logic signed [MID_W-1:0] mid_rv_ff, mid_rv_in;
   logic [THR_W-1:0]        press_thr_ff, press_thr_in;
   logic [THR_W-1:0]        release_thr_ff, release_thr_in;
   logic                    csr_write;

   // pipeline registers
   logic                    in_valid_ff, in_valid_in;
   logic [IN_USED-1:0]      in_data_ff, in_data_in;
   logic                    in_scroll_ff, in_scroll_in;
   logic                    out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]        out_data_ff, out_data_in;
   logic                    out_user_ff, out_user_in;
   logic                    out_ready;
   logic                    fire;
   logic                    req_accept;

   // state
   logic [KEY_W-1:0]        held_ff, held_in;
   logic [31:0]             lr_stamp_ff, lr_stamp_in;
   logic [31:0]             ud_stamp_ff, ud_stamp_in;
   logic [31:0]             scr_stamp_ff, scr_stamp_in;
   logic [31:0]             mou_stamp_ff, mou_stamp_in;

   // datapath signals
   logic [31:0]             now;
   logic signed [CW-1:0]    lx, ly_raw_c, ly, rh, rv;
   logic signed [CW-1:0]    pt_s, rt_s;
   logic [MW-1:0]           mly, mrh, mrv;
   logic                    lr_due, ud_due, scr_due, mou_due;
   logic [KEY_W-1:0]        key_on, key_off, key_due;
   logic [KEY_W-1:0]        press, release_mask;
   logic                    amount_nz;
   logic [PW_SCR-1:0]       prod_scr;
   logic [MW-1:0]           wmag, wneg;
   logic [WHEEL_W-1:0]      wheel;
   logic                    mouse_valid;
   logic [MOVE_W-1:0]       move_x, move_y;

   // centred sample
   function automatic logic signed [CW-1:0] centre_of(
      input logic [ADC_BITS-1:0]    raw,
      input logic signed [MID_W-1:0] mid
   );
      logic signed [CW-1:0] r;
      r = $signed(CW'({1'b0, raw}));
      return r - CW'(CENTRE) - CW'(mid);
   endfunction

   // magnitude of a centred value
   function automatic logic [MW-1:0] mag_of(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] a;
      a = v[CW-1] ? -v : v;
      return a[MW-1:0];
   endfunction

   // mouse step: sign plus range-scaled magnitude over the divisor
   function automatic logic [MOVE_W-1:0] mouse_step(input logic signed [CW-1:0] v);
      logic [MW-1:0]     m;
      logic [SMW-1:0]    sm;
      logic [PW_MOU-1:0] prod;
      logic [SMW-1:0]    mo;
      logic [SMW-1:0]    sv;
      m = mag_of(v);
      if (m < MW'(LO_RANGE)) begin
         sm = SMW'(m >> 2);
      end else if (m > MW'(HI_RANGE)) begin
         sm = {m, 2'b00};
      end else begin
         sm = SMW'(m);
      end
      prod = PW_MOU'(sm) * PW_MOU'(K_MOU);
      mo   = SMW'(prod[PW_MOU-1:S_MOU]) + SMW'(m != '0);
      sv   = v[CW-1] ? -mo : mo;
      return sv[MOVE_W-1:0];
   endfunction

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      mid_lx_in      = mid_lx_ff;
      mid_ly_in      = mid_ly_ff;
      mid_rh_in      = mid_rh_ff;
      mid_rv_in      = mid_rv_ff;
      press_thr_in   = press_thr_ff;
      release_thr_in = release_thr_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_paddr[4:2]))
            REG_MID_LEFT_X:      mid_lx_in      = csr_pwdata[MID_W-1:0];
            REG_MID_LEFT_Y:      mid_ly_in      = csr_pwdata[MID_W-1:0];
            REG_MID_RIGHT_H:     mid_rh_in      = csr_pwdata[MID_W-1:0];
            REG_MID_RIGHT_V:     mid_rv_in      = csr_pwdata[MID_W-1:0];
            REG_PRESS_THRESHOLD: press_thr_in   = csr_pwdata[THR_W-1:0];
            REG_RELEASE_THRESH:  release_thr_in = csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[4:2]))
         REG_MID_LEFT_X:      csr_prdata = CSR_DW'(mid_lx_ff);
         REG_MID_LEFT_Y:      csr_prdata = CSR_DW'(mid_ly_ff);
         REG_MID_RIGHT_H:     csr_prdata = CSR_DW'(mid_rh_ff);
         REG_MID_RIGHT_V:     csr_prdata = CSR_DW'(mid_rv_ff);
         REG_PRESS_THRESHOLD: csr_prdata = CSR_DW'(press_thr_ff);
         REG_RELEASE_THRESH:  csr_prdata = CSR_DW'(release_thr_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // handshake
   assign out_ready  = ~out_valid_ff | rsp_tready;
   assign fire       = in_valid_ff & out_ready;
   assign req_tready = ~in_valid_ff | out_ready;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      in_scroll_in = in_scroll_ff;
      if (req_accept) begin
         in_valid_in  = 1'b1;
         in_data_in   = req_tdata[IN_USED-1:0];
         in_scroll_in = req_tuser;
      end else if (fire) begin
         in_valid_in  = 1'b0;
      end
   end

   // field unpacking and centring
   assign now      = in_data_ff[31:0];
   assign lx       = centre_of(in_data_ff[32 +: ADC_BITS], mid_lx_ff);
   assign ly_raw_c = centre_of(in_data_ff[32 + ADC_BITS +: ADC_BITS], mid_ly_ff);
   assign rh       = centre_of(in_data_ff[32 + 2 * ADC_BITS +: ADC_BITS], mid_rh_ff);
   assign rv       = centre_of(in_data_ff[32 + 3 * ADC_BITS +: ADC_BITS], mid_rv_ff);
   assign pt_s     = $signed(CW'({1'b0, press_thr_ff}));
   assign rt_s     = $signed(CW'({1'b0, release_thr_ff}));

   // dead zone on the left vertical axis
   assign ly  = (mag_of(ly_raw_c) <= MW'(press_thr_ff)) ? '0 : ly_raw_c;
   assign mly = mag_of(ly);
   assign mrh = mag_of(rh);
   assign mrv = mag_of(rv);

   // rate limits on wrapping time differences
   assign lr_due  = (now - lr_stamp_ff) >= 32'(ARROW_WAIT);
   assign ud_due  = ~in_scroll_ff & ((now - ud_stamp_ff) >= 32'(ARROW_WAIT));
   assign scr_due = in_scroll_ff & ((now - scr_stamp_ff) >= 32'(SCROLL_WAIT));
   assign mou_due = (now - mou_stamp_ff) >= 32'(MOUSE_WAIT);

   // schmitt trigger levels per key
   always_comb begin
      key_on[BIT_RIGHT]  = lx > pt_s;
      key_off[BIT_RIGHT] = lx <= rt_s;
      key_on[BIT_LEFT]   = lx < -pt_s;
      key_off[BIT_LEFT]  = lx >= -rt_s;
      key_on[BIT_DOWN]   = ly > pt_s;
      key_off[BIT_DOWN]  = ly <= rt_s;
      key_on[BIT_UP]     = ly < -pt_s;
      key_off[BIT_UP]    = ly >= -rt_s;
      key_due[BIT_RIGHT] = lr_due;
      key_due[BIT_LEFT]  = lr_due;
      key_due[BIT_DOWN]  = ud_due;
      key_due[BIT_UP]    = ud_due;
   end

   // key press and release; a held key releases at its release level even
   // when the press level is also met
   always_comb begin
      for (int k = 0; k < KEY_W; k++) begin
         press[k]        = key_due[k] & key_on[k] & ~held_ff[k];
         release_mask[k] = key_due[k] & key_off[k] & held_ff[k];
      end
   end

   // scroll amount, kept as the negated wheel value
   assign amount_nz = scr_due & (ly != '0);
   assign prod_scr  = PW_SCR'(mly) * PW_SCR'(K_SCR);
   assign wmag      = MW'(prod_scr[PW_SCR-1:S_SCR]) + MW'(1);
   assign wneg      = ly[CW-1] ? wmag : -wmag;
   assign wheel     = wneg[WHEEL_W-1:0];

   // mouse report
   assign mouse_valid = ((mrv > MW'(press_thr_ff)) | (mrh > MW'(press_thr_ff)) | amount_nz)
                        & mou_due;
   assign move_x      = mouse_step(rv);
   assign move_y      = mouse_step(rh);

   // next state and response
   always_comb begin
      held_in      = held_ff;
      lr_stamp_in  = lr_stamp_ff;
      ud_stamp_in  = ud_stamp_ff;
      scr_stamp_in = scr_stamp_ff;
      mou_stamp_in = mou_stamp_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (fire) begin
         held_in      = (held_ff | press) & ~release_mask;
         lr_stamp_in  = lr_due ? now : lr_stamp_ff;
         ud_stamp_in  = ud_due ? now : ud_stamp_ff;
         scr_stamp_in = scr_due ? now : scr_stamp_ff;
         mou_stamp_in = mouse_valid ? now : mou_stamp_ff;
         out_valid_in = 1'b1;
         out_user_in  = mouse_valid;
         out_data_in  = '0;
         out_data_in[RSP_PRESS_LSB +: KEY_W] = press;
         out_data_in[RSP_REL_LSB +: KEY_W]   = release_mask;
         if (mouse_valid) begin
            out_data_in[RSP_MX_LSB +: MOVE_W]  = move_x;
            out_data_in[RSP_MY_LSB +: MOVE_W]  = move_y;
            out_data_in[RSP_WH_LSB +: WHEEL_W] = amount_nz ? wheel : '0;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_lx_ff      <= '0;
         mid_ly_ff      <= '0;
         mid_rh_ff      <= '0;
         mid_rv_ff      <= '0;
         press_thr_ff   <= THR_W'(PRESS_RESET);
         release_thr_ff <= THR_W'(RELEASE_RESET);
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         held_ff        <= '0;
         lr_stamp_ff    <= '0;
         ud_stamp_ff    <= '0;
         scr_stamp_ff   <= '0;
         mou_stamp_ff   <= '0;
      end else begin
         mid_lx_ff      <= mid_lx_in;
         mid_ly_ff      <= mid_ly_in;
         mid_rh_ff      <= mid_rh_in;
         mid_rv_ff      <= mid_rv_in;
         press_thr_ff   <= press_thr_in;
         release_thr_ff <= release_thr_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         held_ff        <= held_in;
         lr_stamp_ff    <= lr_stamp_in;
         ud_stamp_ff    <= ud_stamp_in;
         scr_stamp_ff   <= scr_stamp_in;
         mou_stamp_ff   <= mou_stamp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff   <= in_data_in;
      in_scroll_ff <= in_scroll_in;
      out_data_ff  <= out_data_in;
      out_user_ff  <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

/* rtl/jtam_checker.sv */
`default_nettype none

`include "joystick_to_arrow_and_mouse_unit_defines.svh"

module jtam_checker
   import jtam_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,   // arrow_press, arrow_release, move_x, move_y, wheel
   input logic             rsp_tuser    // mouse_valid
);

   // no response right after reset
   `JTAM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")

   // stalled response holds
   `JTAM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   // without a mouse report, move and wheel are zero
   `JTAM_ASSERT_IMP(a_no_report_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[RSP_W-1:RSP_MX_LSB] == '0, "move or wheel without report")

   // a key is never pressed and released in one response
   `JTAM_ASSERT_IMP(a_press_release, clock, reset, rsp_tvalid, (rsp_tdata[RSP_PRESS_LSB +: KEY_W] & rsp_tdata[RSP_REL_LSB +: KEY_W]) == '0, "key pressed and released together")

   // opposite arrows never press together
   `JTAM_ASSERT_IMP(a_opposite_press, clock, reset, rsp_tvalid, !(rsp_tdata[BIT_RIGHT] && rsp_tdata[BIT_LEFT]) && !(rsp_tdata[BIT_DOWN] && rsp_tdata[BIT_UP]), "opposite arrows pressed together")

endmodule

bind joystick_to_arrow_and_mouse_unit jtam_checker u_jtam_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import jtam_pkg::*;

   localparam int REQ_W = req_tdata_bits(ADC_BITS_DEFAULT);
   localparam int RANGE_FACTOR = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_FRAMES = 100;
   localparam int MAX_REPORTS = 100;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_type;

   typedef struct {
      logic [31:0] now_ms;
      logic [11:0] left_x;
      logic [11:0] left_y;
      logic [11:0] right_h;
      logic [11:0] right_v;
      logic        scroll;
   } frame_type;

   typedef struct {
      logic [KEY_W-1:0]   pressed;
      logic [KEY_W-1:0]   released;
      logic               mouse;
      logic [MOVE_W-1:0]  move_x;
      logic [MOVE_W-1:0]  move_y;
      logic [WHEEL_W-1:0] wheel;
   } response_type;

   // dut ports
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;    // now_ms, left_x_raw, left_y_raw, right_h_raw, right_v_raw
   logic              req_tuser = 1'b0;  // scroll_mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // arrow_press, arrow_release, move_x, move_y, wheel
   logic              rsp_tuser;         // mouse_valid
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // predictor copy of the settings and the key and rate state
   int          mid_lx = 0;
   int          mid_ly = 0;
   int          mid_rh = 0;
   int          mid_rv = 0;
   int          press_thr = PRESS_RESET;
   int          release_thr = RELEASE_RESET;
   logic [3:0]  keys_held = '0;
   logic [31:0] lr_stamp = '0;
   logic [31:0] ud_stamp = '0;
   logic [31:0] wheel_stamp = '0;
   logic [31:0] move_stamp = '0;

   // stimulus and scoreboard
   frame_type     frame_q[$];
   response_type  response_q[$];
   frame_type     on_bus;
   frame_type     last_frame = '{default: '0};
   logic [31:0]   sim_ms = '0;
   bit            scroll_on = 1'b0;
   idle_mode_type idle_mode = IDLE_NONE;
   idle_mode_type phase_mode [8] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                     IDLE_HOLD, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
   int            hold_count = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   joystick_to_arrow_and_mouse_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int sign_of(input int v);
      return v > 0 ? 1 : (v < 0 ? -1 : 0);
   endfunction

   function automatic int abs_of(input int v);
      return v < 0 ? -v : v;
   endfunction

   // small moves are damped, large ones boosted
   function automatic int range_scaled(input int v);
      int s;
      s = v;
      if (abs_of(s) < LO_RANGE) s = s / RANGE_FACTOR;
      if (abs_of(s) > HI_RANGE) s = s * RANGE_FACTOR;
      return s;
   endfunction

   // hysteresis for one arrow key, positive side when hi
   function automatic void schmitt_key(input int v, input int idx, input bit hi,
                                      inout logic [3:0] pr, inout logic [3:0] rl);
      bit on_lvl;
      bit off_lvl;
      on_lvl = hi ? (v > press_thr) : (v < -press_thr);
      off_lvl = hi ? (v <= release_thr) : (v >= -release_thr);
      if (on_lvl && !keys_held[idx]) begin
         keys_held[idx] = 1'b1;
         pr[idx] = 1'b1;
      end else if (off_lvl && keys_held[idx]) begin
         keys_held[idx] = 1'b0;
         rl[idx] = 1'b1;
      end
   endfunction

   // response for one frame, updating held keys and rate stamps
   function automatic response_type predict_response(input frame_type f);
      response_type r;
      int          lx;
      int          ly;
      int          rh;
      int          rv;
      int          amount;
      int          mx;
      int          my;
      logic [3:0]  pr;
      logic [3:0]  rl;
      logic [31:0] since;
      r = '{default: '0};
      pr = '0;
      rl = '0;
      amount = 0;
      lx = int'(f.left_x) - CENTRE - mid_lx;
      ly = int'(f.left_y) - CENTRE - mid_ly;
      rh = int'(f.right_h) - CENTRE - mid_rh;
      rv = int'(f.right_v) - CENTRE - mid_rv;
      if (abs_of(ly) <= press_thr) ly = 0;

      since = f.now_ms - lr_stamp;
      if (since >= ARROW_WAIT) begin
         schmitt_key(lx, BIT_RIGHT, 1'b1, pr, rl);
         schmitt_key(lx, BIT_LEFT, 1'b0, pr, rl);
         lr_stamp = f.now_ms;
      end

      // vertical axis: wheel in scroll mode, else down/up keys
      if (f.scroll) begin
         since = f.now_ms - wheel_stamp;
         if (since >= SCROLL_WAIT) begin
            amount = sign_of(ly) + ly / SCROLL_DIV;
            wheel_stamp = f.now_ms;
         end
      end else begin
         since = f.now_ms - ud_stamp;
         if (since >= ARROW_WAIT) begin
            schmitt_key(ly, BIT_DOWN, 1'b1, pr, rl);
            schmitt_key(ly, BIT_UP, 1'b0, pr, rl);
            ud_stamp = f.now_ms;
         end
      end

      // mouse report, rate limited; a throttled wheel amount is dropped
      since = f.now_ms - move_stamp;
      if ((abs_of(rv) > press_thr || abs_of(rh) > press_thr || amount != 0)
          && since >= MOUSE_WAIT) begin
         mx = sign_of(rv) + range_scaled(rv) / MOUSE_DIV;
         my = sign_of(rh) + range_scaled(rh) / MOUSE_DIV;
         r.mouse = 1'b1;
         r.move_x = mx[MOVE_W-1:0];
         r.move_y = my[MOVE_W-1:0];
         amount = -amount;
         r.wheel = amount[WHEEL_W-1:0];
         move_stamp = f.now_ms;
      end
      r.pressed = pr;
      r.released = rl;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // csr write: setup then access cycle, mirrored into the predictor
   task automatic csr_write(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(int'(idx) * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MID_LEFT_X:      mid_lx = $signed(value[11:0]);
         REG_MID_LEFT_Y:      mid_ly = $signed(value[11:0]);
         REG_MID_RIGHT_H:     mid_rh = $signed(value[11:0]);
         REG_MID_RIGHT_V:     mid_rv = $signed(value[11:0]);
         REG_PRESS_THRESHOLD: press_thr = value[10:0];
         REG_RELEASE_THRESH:  release_thr = value[10:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int mlx, input int mly, input int mrh,
                                 input int mrv, input int pth, input int rth);
      csr_write(REG_MID_LEFT_X, mlx);
      csr_write(REG_MID_LEFT_Y, mly);
      csr_write(REG_MID_RIGHT_H, mrh);
      csr_write(REG_MID_RIGHT_V, mrv);
      csr_write(REG_PRESS_THRESHOLD, pth);
      csr_write(REG_RELEASE_THRESH, rth);
   endtask

   task automatic push_frame(input logic [31:0] t, input int lx, input int ly,
                             input int rh, input int rv, input bit sc);
      frame_type f;
      f.now_ms = t;
      f.left_x = lx[11:0];
      f.left_y = ly[11:0];
      f.right_h = rh[11:0];
      f.right_v = rv[11:0];
      f.scroll = sc;
      frame_q.push_back(f);
   endtask

   // stick position: often held, else random, extreme or near a threshold
   function automatic logic [11:0] stick_sample(input logic [11:0] prev, input int mid);
      int pick;
      int span;
      int v;
      pick = $urandom_range(99);
      span = press_thr + 60;
      if (pick < 30) return prev;
      if (pick < 50) return 12'($urandom_range(4095));
      if (pick < 58) return ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
      if (pick < 85) v = int'($urandom_range(2 * span)) - span;
      else begin
         v = int'($urandom_range(1850, 1150));
         if ($urandom_range(1) != 0) v = -v;
      end
      v = v + CENTRE + mid;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   function automatic frame_type next_random_frame();
      frame_type f;
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) sim_ms = $urandom();
      else if (pick < 60) sim_ms += $urandom_range(60);
      else if (pick < 90) sim_ms += $urandom_range(150);
      else sim_ms += $urandom_range(12);
      if ($urandom_range(99) < 8) scroll_on = !scroll_on;
      f.now_ms = sim_ms;
      f.left_x = stick_sample(last_frame.left_x, mid_lx);
      f.left_y = stick_sample(last_frame.left_y, mid_ly);
      f.right_h = stick_sample(last_frame.right_h, mid_rh);
      f.right_v = stick_sample(last_frame.right_v, mid_rv);
      f.scroll = scroll_on;
      last_frame = f;
      return f;
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(99) < 73;
         IDLE_BOTH: return $urandom_range(99) < 21;
         default:   return 1'b0;
      endcase
   endfunction

   // sender pause: wait until nothing is pending or expected
   task automatic wait_drained();
      do @(posedge clock);
      while (frame_q.size() != 0 || req_tvalid || response_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) response_q.push_back(predict_response(on_bus));
         if (!req_tvalid || req_tready) begin
            if (frame_q.size() != 0 && !sender_idles()) begin
               on_bus = frame_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_bus.right_v, on_bus.right_h, on_bus.left_y,
                             on_bus.left_x, on_bus.now_ms};
               req_tuser <= on_bus.scroll;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECV: rsp_tready <= ($urandom_range(99) >= 73);
            IDLE_BOTH: rsp_tready <= ($urandom_range(99) >= 21);
            default:   rsp_tready <= 1'b1;
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (response_q.size() == 0) begin
            report_mismatch("response with nothing expected", rsp_tdata[31:0], '0);
         end else begin
            want = response_q.pop_front();
            check_field("arrow_press", rsp_tdata[RSP_PRESS_LSB +: KEY_W], want.pressed);
            check_field("arrow_release", rsp_tdata[RSP_REL_LSB +: KEY_W], want.released);
            check_field("mouse_valid", rsp_tuser, want.mouse);
            check_field("move_x", rsp_tdata[RSP_MX_LSB +: MOVE_W], want.move_x);
            check_field("move_y", rsp_tdata[RSP_MY_LSB +: MOVE_W], want.move_y);
            check_field("wheel", rsp_tdata[RSP_WH_LSB +: WHEEL_W], want.wheel);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int pth;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frames at reset settings
      push_frame(32'd0, CENTRE, CENTRE, CENTRE, CENTRE, 1'b0);
      push_frame(32'd5, 4095, CENTRE, CENTRE, CENTRE, 1'b0);
      push_frame(32'd200, 4095, CENTRE, CENTRE, 4095, 1'b0);
      push_frame(32'd205, 0, CENTRE, CENTRE, 0, 1'b0);
      push_frame(32'd300, 0, CENTRE, 4095, 0, 1'b0);
      push_frame(32'd400, CENTRE - 90, 4095, CENTRE + 1199, CENTRE, 1'b0);
      push_frame(32'd500, CENTRE - 80, 0, CENTRE + 1200, CENTRE, 1'b0);
      push_frame(32'd600, CENTRE + 101, CENTRE, CENTRE + 1800, CENTRE + 1801, 1'b0);
      push_frame(32'd700, CENTRE + 100, CENTRE + 100, CENTRE, CENTRE, 1'b0);
      push_frame(32'd710, CENTRE + 100, 4095, CENTRE, CENTRE, 1'b1);
      push_frame(32'd760, CENTRE + 100, 0, CENTRE, CENTRE, 1'b1);
      push_frame(32'd820, CENTRE, CENTRE - 600, CENTRE, CENTRE, 1'b1);
      push_frame(32'd830, CENTRE, CENTRE - 101, CENTRE, 4095, 1'b1);
      // time stamps wrapping and stepping backwards
      push_frame(32'hFFFF_FFF0, CENTRE, 4095, CENTRE, CENTRE + 101, 1'b0);
      push_frame(32'h0000_0005, 0, 4095, CENTRE, CENTRE, 1'b0);
      push_frame(32'h0000_0040, 0, 4095, 0, 0, 1'b1);
      push_frame(32'h0000_0100, 4095, 4095, 4095, 4095, 1'b0);
      push_frame(32'h0000_0200, 0, 0, 0, 0, 1'b0);
      push_frame(32'h0000_0300, CENTRE, CENTRE, CENTRE, CENTRE, 1'b0);
      push_frame(32'h0000_0300, 4095, 0, CENTRE - 100, CENTRE + 100, 1'b0);
      sim_ms = 32'h0000_0300;
      wait_drained();

      // random phases, each with new settings and an idling pattern from phase_mode
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_settings(0, 0, 0, 0, PRESS_RESET, RELEASE_RESET);
            1: apply_settings(-2048, -2048, -2048, -2048, 2047, 0);
            2: apply_settings(2047, 2047, 2047, 2047, 0, 2047);
            6: apply_settings(int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(2047)), int'($urandom_range(2047)));
            7: apply_settings(5, -7, 12, -3, 300, 150);
            default: begin
               pth = $urandom_range(400, 40);
               apply_settings(int'($urandom_range(600)) - 300,
                              int'($urandom_range(600)) - 300,
                              int'($urandom_range(600)) - 300,
                              int'($urandom_range(600)) - 300,
                              pth, int'($urandom_range(pth)));
            end
         endcase
         if (p == 5) sim_ms = 32'hFFFF_F000;
         idle_mode = phase_mode[p];
         for (int i = 0; i < PHASE_FRAMES; i++) frame_q.push_back(next_random_frame());
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/jtam_pkg.sv
rtl/joystick_to_arrow_and_mouse_unit.sv
rtl/jtam_checker.sv
dv/tb_top.sv
